// ----- hdl/pps_pkg.sv -----
// shared constants, codes and helpers for the preemptive priority scheduler
`timescale 1ns / 1ps
`default_nettype none

package pps_pkg;

    // default table depth
    localparam int MAX_PROCESSES_DEF = 16;

    // field widths
    localparam int TIME_W  = 24;
    localparam int ARR_W   = 16;
    localparam int BURST_W = 16;
    localparam int PRIO_W  = 8;
    localparam int SLOT_OUT_W = 4;

    // signed width of the raw time differences before clamping
    localparam int DIFF_W = TIME_W + 2;

    // request kinds
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // largest time value
    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    // clamp a signed difference to 0 .. TIME_MAX
    function automatic logic [TIME_W-1:0] clamp_time(input logic [DIFF_W-1:0] v);
        logic [TIME_W-1:0] r;
        if (v[DIFF_W-1])
            r = '0;
        else if (v[DIFF_W-2])
            r = TIME_MAX;
        else
            r = v[TIME_W-1:0];
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/preemptive_priority_scheduler.sv -----
// preemptive priority scheduler: process table, tick sequencer and selection scan
//
// channel   direction  handshake              payload
// request   in         req_valid / req_stall  kind, arrival_time, burst_time, priority_level
// result    out        rsp_valid / rsp_stall  tick_time, running_slot, did_run, finished,
//                                             wait_time, turnaround_time, next_slot
//
// a load request does not raise req_stall and never produces a result.
// a tick request holds req_stall through a read of the current slot, an update
// step, a scan of one table entry per cycle through the single table read port
// plus one drain step, and a step to post the result.
// rst_n is asynchronous and clears control state; the tables are undefined until loaded.
// a result waits in the output register while rsp_stall is high; a following
// tick finishes its scan and then holds until that register is free.
`timescale 1ns / 1ps
`default_nettype none

module preemptive_priority_scheduler
    import pps_pkg::*;
#(
    parameter int MAX_PROCESSES = MAX_PROCESSES_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    input  wire logic                  req_valid,
    output      logic                  req_stall,
    input  wire logic                  kind,
    input  wire logic [ARR_W-1:0]      arrival_time,
    input  wire logic [BURST_W-1:0]    burst_time,
    input  wire logic [PRIO_W-1:0]     priority_level,

    output      logic                  rsp_valid,
    input  wire logic                  rsp_stall,
    output      logic [TIME_W-1:0]     tick_time,
    output      logic [SLOT_OUT_W-1:0] running_slot,
    output      logic                  did_run,
    output      logic                  finished,
    output      logic [TIME_W-1:0]     wait_time,
    output      logic [TIME_W-1:0]     turnaround_time,
    output      logic [SLOT_OUT_W-1:0] next_slot
);

    localparam int SLOT_W = $clog2(MAX_PROCESSES);
    localparam int CNT_W  = $clog2(MAX_PROCESSES + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CUR_RD,
        ST_UPD,
        ST_SCAN,
        ST_FINISH
    } state_t;

    // process tables
    logic [ARR_W-1:0]   arr_mem   [MAX_PROCESSES];
    logic [BURST_W-1:0] burst_mem [MAX_PROCESSES];
    logic [BURST_W-1:0] rem_mem   [MAX_PROCESSES];
    logic [PRIO_W-1:0]  prio_mem  [MAX_PROCESSES];

    logic [ARR_W-1:0]   rd_arr;
    logic [BURST_W-1:0] rd_burst;
    logic [BURST_W-1:0] rd_rem;
    logic [PRIO_W-1:0]  rd_prio;

    // control and result registers
    state_t                  state_reg, state_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [SLOT_W-1:0]       cur_reg, cur_next;
    logic [ARR_W-1:0]        cur_arr_reg, cur_arr_next;
    logic [TIME_W-1:0]       time_now_reg, time_now_next;
    logic                    ticked_reg, ticked_next;
    logic [MAX_PROCESSES-1:0] done_reg, done_next;
    logic [TIME_W:0]         t1_reg, t1_next;
    logic                    run_reg, run_next;
    logic                    fin_reg, fin_next;
    logic [DIFF_W-1:0]       ta_raw_reg, ta_raw_next;
    logic [BURST_W-1:0]      burst_reg, burst_next;
    logic [CNT_W-1:0]        issue_reg, issue_next;
    logic                    eval_valid_reg, eval_valid_next;
    logic [SLOT_W-1:0]       eval_idx_reg, eval_idx_next;
    logic                    found_reg, found_next;
    logic [SLOT_W-1:0]       best_reg, best_next;
    logic [PRIO_W-1:0]       best_prio_reg, best_prio_next;
    logic [ARR_W-1:0]        best_arr_reg, best_arr_next;

    logic                    rsp_valid_reg, rsp_valid_next;
    logic [TIME_W-1:0]       tick_time_reg, tick_time_next;
    logic [SLOT_OUT_W-1:0]   running_slot_reg, running_slot_next;
    logic                    did_run_reg, did_run_next;
    logic                    finished_reg, finished_next;
    logic [TIME_W-1:0]       wait_time_reg, wait_time_next;
    logic [TIME_W-1:0]       turnaround_reg, turnaround_next;
    logic [SLOT_OUT_W-1:0]   next_slot_reg, next_slot_next;

    // table port controls
    logic                    tbl_we;
    logic [SLOT_W-1:0]       tbl_waddr;
    logic                    rem_we;
    logic [SLOT_W-1:0]       rem_waddr;
    logic [BURST_W-1:0]      rem_wdata;
    logic [SLOT_W-1:0]       rd_addr;

    // datapath terms
    logic                    accept;
    logic                    cur_loaded;
    logic                    run_now;
    logic [BURST_W-1:0]      rem_new;
    logic                    cand;
    logic                    better;
    logic [DIFF_W-1:0]       wt_raw;
    logic                    out_free;

    assign req_stall       = (state_reg != ST_IDLE);
    assign accept          = req_valid && !req_stall;
    assign rsp_valid       = rsp_valid_reg;
    assign tick_time       = tick_time_reg;
    assign running_slot    = running_slot_reg;
    assign did_run         = did_run_reg;
    assign finished        = finished_reg;
    assign wait_time       = wait_time_reg;
    assign turnaround_time = turnaround_reg;
    assign next_slot       = next_slot_reg;

    // current slot update terms
    assign cur_loaded = (CNT_W'(cur_reg) < count_reg);
    assign run_now    = cur_loaded && (rd_rem != '0)
                        && ({{(TIME_W-ARR_W){1'b0}}, rd_arr} <= time_now_reg);
    assign rem_new    = rd_rem - BURST_W'(run_now);

    // selection scan compare
    assign cand   = eval_valid_reg && !done_reg[eval_idx_reg]
                    && ({{(TIME_W+1-ARR_W){1'b0}}, rd_arr} <= t1_reg);
    assign better = !found_reg || (rd_prio < best_prio_reg)
                    || ((rd_prio == best_prio_reg) && (rd_arr < best_arr_reg));

    // waiting time from turnaround and burst
    assign wt_raw   = ta_raw_reg - {{(DIFF_W-BURST_W){1'b0}}, burst_reg};
    assign out_free = !rsp_valid_reg || !rsp_stall;

    // table read address
    always_comb
    begin
        if (state_reg == ST_SCAN)
            rd_addr = issue_reg[SLOT_W-1:0];
        else
            rd_addr = cur_reg;
    end

    // sequencer next state
    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        cur_next          = cur_reg;
        cur_arr_next      = cur_arr_reg;
        time_now_next     = time_now_reg;
        ticked_next       = ticked_reg;
        done_next         = done_reg;
        t1_next           = t1_reg;
        run_next          = run_reg;
        fin_next          = fin_reg;
        ta_raw_next       = ta_raw_reg;
        burst_next        = burst_reg;
        issue_next        = issue_reg;
        eval_valid_next   = 1'b0;
        eval_idx_next     = eval_idx_reg;
        found_next        = found_reg;
        best_next         = best_reg;
        best_prio_next    = best_prio_reg;
        best_arr_next     = best_arr_reg;
        rsp_valid_next    = rsp_valid_reg && rsp_stall;
        tick_time_next    = tick_time_reg;
        running_slot_next = running_slot_reg;
        did_run_next      = did_run_reg;
        finished_next     = finished_reg;
        wait_time_next    = wait_time_reg;
        turnaround_next   = turnaround_reg;
        next_slot_next    = next_slot_reg;
        tbl_we            = 1'b0;
        tbl_waddr         = count_reg[SLOT_W-1:0];
        rem_we            = 1'b0;
        rem_waddr         = count_reg[SLOT_W-1:0];
        rem_wdata         = burst_time;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (kind == KIND_TICK)
                    begin
                        ticked_next = 1'b1;
                        state_next  = ST_CUR_RD;
                    end
                    else if (count_reg < CNT_W'(MAX_PROCESSES))
                    begin
                        // store the request in the next free slot
                        tbl_we     = 1'b1;
                        rem_we     = 1'b1;
                        done_next[count_reg[SLOT_W-1:0]] = 1'b0;
                        count_next = count_reg + CNT_W'(1);
                        // before the first tick, track the earliest arrival
                        if (!ticked_reg && ((count_reg == '0) || (arrival_time < cur_arr_reg)))
                        begin
                            cur_next     = count_reg[SLOT_W-1:0];
                            cur_arr_next = arrival_time;
                        end
                    end
                end
            end

            ST_CUR_RD:
            begin
                state_next = ST_UPD;
            end

            ST_UPD:
            begin
                // run the current slot one unit and check completion
                run_next    = run_now;
                fin_next    = cur_loaded && (rem_new == '0) && !done_reg[cur_reg];
                rem_we      = run_now;
                rem_waddr   = cur_reg;
                rem_wdata   = rem_new;
                if (cur_loaded && (rem_new == '0))
                    done_next[cur_reg] = 1'b1;
                t1_next     = {1'b0, time_now_reg} + (TIME_W+1)'(1);
                ta_raw_next = {{(DIFF_W-TIME_W){1'b0}}, time_now_reg} + DIFF_W'(1)
                              - {{(DIFF_W-ARR_W){1'b0}}, rd_arr};
                burst_next  = rd_burst;
                issue_next  = '0;
                found_next  = 1'b0;
                best_next   = cur_reg;
                state_next  = ST_SCAN;
            end

            ST_SCAN:
            begin
                // issue one table read per cycle
                if (issue_reg < count_reg)
                begin
                    eval_valid_next = 1'b1;
                    eval_idx_next   = issue_reg[SLOT_W-1:0];
                    issue_next      = issue_reg + CNT_W'(1);
                end
                else
                begin
                    state_next = ST_FINISH;
                end
                // compare the entry read last cycle
                if (cand && better)
                begin
                    found_next     = 1'b1;
                    best_next      = eval_idx_reg;
                    best_prio_next = rd_prio;
                    best_arr_next  = rd_arr;
                end
            end

            ST_FINISH:
            begin
                if (out_free)
                begin
                    rsp_valid_next    = 1'b1;
                    tick_time_next    = time_now_reg;
                    running_slot_next = SLOT_OUT_W'(cur_reg);
                    did_run_next      = run_reg;
                    finished_next     = fin_reg;
                    wait_time_next    = fin_reg ? clamp_time(wt_raw) : '0;
                    turnaround_next   = fin_reg ? clamp_time(ta_raw_reg) : '0;
                    next_slot_next    = SLOT_OUT_W'(best_reg);
                    cur_next          = best_reg;
                    if (time_now_reg != TIME_MAX)
                        time_now_next = time_now_reg + TIME_W'(1);
                    state_next        = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            count_reg        <= '0;
            cur_reg          <= '0;
            cur_arr_reg      <= '0;
            time_now_reg     <= '0;
            ticked_reg       <= 1'b0;
            done_reg         <= '0;
            t1_reg           <= '0;
            run_reg          <= 1'b0;
            fin_reg          <= 1'b0;
            ta_raw_reg       <= '0;
            burst_reg        <= '0;
            issue_reg        <= '0;
            eval_valid_reg   <= 1'b0;
            eval_idx_reg     <= '0;
            found_reg        <= 1'b0;
            best_reg         <= '0;
            best_prio_reg    <= '0;
            best_arr_reg     <= '0;
            rsp_valid_reg    <= 1'b0;
            tick_time_reg    <= '0;
            running_slot_reg <= '0;
            did_run_reg      <= 1'b0;
            finished_reg     <= 1'b0;
            wait_time_reg    <= '0;
            turnaround_reg   <= '0;
            next_slot_reg    <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            cur_reg          <= cur_next;
            cur_arr_reg      <= cur_arr_next;
            time_now_reg     <= time_now_next;
            ticked_reg       <= ticked_next;
            done_reg         <= done_next;
            t1_reg           <= t1_next;
            run_reg          <= run_next;
            fin_reg          <= fin_next;
            ta_raw_reg       <= ta_raw_next;
            burst_reg        <= burst_next;
            issue_reg        <= issue_next;
            eval_valid_reg   <= eval_valid_next;
            eval_idx_reg     <= eval_idx_next;
            found_reg        <= found_next;
            best_reg         <= best_next;
            best_prio_reg    <= best_prio_next;
            best_arr_reg     <= best_arr_next;
            rsp_valid_reg    <= rsp_valid_next;
            tick_time_reg    <= tick_time_next;
            running_slot_reg <= running_slot_next;
            did_run_reg      <= did_run_next;
            finished_reg     <= finished_next;
            wait_time_reg    <= wait_time_next;
            turnaround_reg   <= turnaround_next;
            next_slot_reg    <= next_slot_next;
        end
    end

    // process tables: one write port each, one shared read address with registered read data
    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            arr_mem[tbl_waddr]   <= arrival_time;
            burst_mem[tbl_waddr] <= burst_time;
            prio_mem[tbl_waddr]  <= priority_level;
        end
        if (rem_we)
            rem_mem[rem_waddr] <= rem_wdata;
        rd_arr   <= arr_mem[rd_addr];
        rd_burst <= burst_mem[rd_addr];
        rd_rem   <= rem_mem[rd_addr];
        rd_prio  <= prio_mem[rd_addr];
    end

    // table never holds more than its depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_PROCESSES))
        else $error("entry count above table depth");

    // a result only appears out of the finish step
    a_rsp_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("result posted outside finish step");

    // time only advances when a tick completes
    a_time_on_finish: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(time_now_reg) |-> $past(state_reg == ST_FINISH))
        else $error("time changed outside finish step");

    // a completed slot is marked done for the rest of the tick
    a_fin_marks_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && fin_reg) |-> done_reg[cur_reg])
        else $error("finished slot not marked done");

    // pending compares only live inside the scan
    a_eval_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        eval_valid_reg |-> (state_reg == ST_SCAN))
        else $error("scan compare outside scan");

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
// self-checking bench for the preemptive priority scheduler: loads, ticks and schedule checks
`timescale 1ns / 1ps

module tb;
    import pps_pkg::*;

    localparam int MAX_PROCS   = MAX_PROCESSES_DEF;
    localparam int ITEM_TARGET = 1450;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 40;
    localparam int QUIET_TAIL  = 150;
    localparam int NO_PRIO     = 999;

    // one request as queued for the driver
    typedef struct packed {
        logic               kind;
        logic [ARR_W-1:0]   arr;
        logic [BURST_W-1:0] bur;
        logic [PRIO_W-1:0]  pri;
        logic               pause;
    } sched_req_t;

    // one tick report as the block should post it
    typedef struct packed {
        logic [TIME_W-1:0]     tick_time;
        logic [SLOT_OUT_W-1:0] running_slot;
        logic                  did_run;
        logic                  finished;
        logic [TIME_W-1:0]     wait_time;
        logic [TIME_W-1:0]     turnaround_time;
        logic [SLOT_OUT_W-1:0] next_slot;
    } tick_report_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  req_valid = 1'b0;
    logic                  req_stall;
    logic                  kind = KIND_LOAD;
    logic [ARR_W-1:0]      arrival_time = '0;
    logic [BURST_W-1:0]    burst_time = '0;
    logic [PRIO_W-1:0]     priority_level = '0;
    logic                  rsp_valid;
    logic                  rsp_stall = 1'b0;
    logic [TIME_W-1:0]     tick_time;
    logic [SLOT_OUT_W-1:0] running_slot;
    logic                  did_run;
    logic                  finished;
    logic [TIME_W-1:0]     wait_time;
    logic [TIME_W-1:0]     turnaround_time;
    logic [SLOT_OUT_W-1:0] next_slot;

    sched_req_t   request_q[$];
    tick_report_t tick_reports_q[$];
    int           err_count = 0;
    int           cycle_count = 0;
    int           send_gap = 0;
    int           stall_left = 0;
    int           ticks_queued = 0;
    int           loads_queued = 0;
    bit           pause_next = 1'b0;

    // scheduler shadow state
    logic [ARR_W-1:0]   proc_arrival[MAX_PROCS];
    logic [BURST_W-1:0] proc_burst[MAX_PROCS];
    logic [BURST_W-1:0] proc_left[MAX_PROCS];
    logic [PRIO_W-1:0]  proc_prio[MAX_PROCS];
    bit                 proc_done[MAX_PROCS];
    int unsigned        procs_loaded = 0;
    int unsigned        cur_slot = 0;
    logic [TIME_W-1:0]  sched_now = '0;
    bit                 has_ticked = 1'b0;

    preemptive_priority_scheduler u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_valid       (req_valid),
        .req_stall       (req_stall),
        .kind            (kind),
        .arrival_time    (arrival_time),
        .burst_time      (burst_time),
        .priority_level  (priority_level),
        .rsp_valid       (rsp_valid),
        .rsp_stall       (rsp_stall),
        .tick_time       (tick_time),
        .running_slot    (running_slot),
        .did_run         (did_run),
        .finished        (finished),
        .wait_time       (wait_time),
        .turnaround_time (turnaround_time),
        .next_slot       (next_slot)
    );

    always #4 clk = ~clk;

    task automatic flag_error(string msg);
        $display("ERROR @%0t: %s", $time, msg);
        err_count++;
    endtask

    task automatic check_field(string what, logic [TIME_W-1:0] got, logic [TIME_W-1:0] want);
        if (got !== want)
            flag_error($sformatf("%s got %0d expected %0d", what, got, want));
    endtask

    // earlier arrival first, lower slot on ties
    function automatic bit goes_first(int unsigned a, int unsigned b);
        if (proc_arrival[a] != proc_arrival[b])
            return proc_arrival[a] < proc_arrival[b];
        return a < b;
    endfunction

    function automatic logic [TIME_W-1:0] sat_time(longint v);
        if (v < 0)
            return '0;
        if (v > longint'(TIME_MAX))
            return TIME_MAX;
        return v[TIME_W-1:0];
    endfunction

    // apply one accepted request to the shadow scheduler, queue the tick report
    task automatic schedule_request(input logic k, input logic [ARR_W-1:0] arr,
                                    input logic [BURST_W-1:0] bur,
                                    input logic [PRIO_W-1:0] pri);
        tick_report_t rep;
        int unsigned  s;
        int unsigned  best;
        int unsigned  best_pr;
        longint       t1;
        if (k == KIND_LOAD) begin
            if (procs_loaded < MAX_PROCS) begin
                s = procs_loaded;
                proc_arrival[s] = arr;
                proc_burst[s]   = bur;
                proc_left[s]    = bur;
                proc_prio[s]    = pri;
                proc_done[s]    = 1'b0;
                procs_loaded++;
                // before any tick the earliest arrival is current
                if (!has_ticked) begin
                    best = 0;
                    for (s = 1; s < procs_loaded; s++)
                        if (goes_first(s, best))
                            best = s;
                    cur_slot = best;
                end
            end
        end
        else begin
            has_ticked = 1'b1;
            t1  = longint'(sched_now) + 1;
            rep = '0;
            s   = cur_slot;
            rep.tick_time    = sched_now;
            rep.running_slot = s[SLOT_OUT_W-1:0];
            if (s < procs_loaded) begin
                if (proc_left[s] > 0 && proc_arrival[s] <= sched_now) begin
                    proc_left[s]--;
                    rep.did_run = 1'b1;
                end
                if (proc_left[s] == 0 && !proc_done[s]) begin
                    proc_done[s] = 1'b1;
                    rep.finished = 1'b1;
                    rep.wait_time = sat_time(t1 - longint'(proc_burst[s])
                                             - longint'(proc_arrival[s]));
                    rep.turnaround_time = sat_time(t1 - longint'(proc_arrival[s]));
                end
            end
            // preemptive pick among arrived, unfinished processes
            best    = cur_slot;
            best_pr = NO_PRIO;
            for (s = 0; s < procs_loaded; s++) begin
                if (proc_done[s] || longint'(proc_arrival[s]) > t1)
                    continue;
                if (proc_prio[s] < best_pr ||
                    (best_pr != NO_PRIO && proc_prio[s] == best_pr && goes_first(s, best))) begin
                    best_pr = 32'(proc_prio[s]);
                    best    = s;
                end
            end
            cur_slot      = best;
            rep.next_slot = best[SLOT_OUT_W-1:0];
            if (sched_now != TIME_MAX)
                sched_now++;
            tick_reports_q.push_back(rep);
        end
    endtask

    task automatic queue_load(input logic [ARR_W-1:0] arr, input logic [BURST_W-1:0] bur,
                              input logic [PRIO_W-1:0] pri);
        request_q.push_back('{kind: KIND_LOAD, arr: arr, bur: bur, pri: pri, pause: pause_next});
        pause_next = 1'b0;
        loads_queued++;
    endtask

    // tick fields are unused by the block, so they carry random bits
    task automatic queue_tick();
        request_q.push_back('{kind: KIND_TICK,
                              arr: ARR_W'($urandom), bur: BURST_W'($urandom),
                              pri: PRIO_W'($urandom), pause: pause_next});
        pause_next = 1'b0;
        ticks_queued++;
    endtask

    function automatic bit idling_allowed();
        return request_q.size() >= QUIET_TAIL && cycle_count[9:8] != 2'b11;
    endfunction

    // run limit
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // request driver
    always @(posedge clk) begin : driver
        sched_req_t nxt;
        bit         have;
        if (rst_n) begin
            have = req_valid;
            if (req_valid && !req_stall) begin
                schedule_request(kind, arrival_time, burst_time, priority_level);
                have = 1'b0;
            end
            if (!have) begin
                if (send_gap != 0)
                    send_gap--;
                else if (request_q.size() != 0 &&
                         !(request_q[0].pause && tick_reports_q.size() != 0)) begin
                    if (idling_allowed() && $urandom_range(0, 7) == 0)
                        send_gap = $urandom_range(0, 13);
                    else begin
                        nxt            = request_q.pop_front();
                        kind           <= nxt.kind;
                        arrival_time   <= nxt.arr;
                        burst_time     <= nxt.bur;
                        priority_level <= nxt.pri;
                        have           = 1'b1;
                    end
                end
            end
            req_valid <= have;
        end
    end

    // result backpressure
    always @(posedge clk) begin
        if (stall_left != 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
        end
        else if (idling_allowed() && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(0, 13);
            rsp_stall <= 1'b1;
        end
        else
            rsp_stall <= 1'b0;
    end

    // result checker
    always @(posedge clk) begin : monitor
        tick_report_t want;
        if (rst_n && rsp_valid && !rsp_stall) begin
            if (tick_reports_q.size() == 0)
                flag_error("tick report with no tick request outstanding");
            else begin
                want = tick_reports_q.pop_front();
                check_field("tick_time", tick_time, want.tick_time);
                check_field("running_slot", TIME_W'(running_slot),
                            TIME_W'(want.running_slot));
                check_field("did_run", TIME_W'(did_run), TIME_W'(want.did_run));
                check_field("finished", TIME_W'(finished), TIME_W'(want.finished));
                check_field("wait_time", wait_time, want.wait_time);
                check_field("turnaround_time", turnaround_time, want.turnaround_time);
                check_field("next_slot", TIME_W'(next_slot), TIME_W'(want.next_slot));
            end
        end
    end

    // stimulus and end of run
    initial begin
        int          n_counted;
        int          i;
        longint      a;
        logic [15:0] b;
        logic [7:0]  p;

        // loads before the first tick: earliest arrival wins, lower slot on ties
        queue_load(16'd4, 16'd3, 8'd5);
        queue_load(16'd2, 16'd2, 8'd9);
        queue_load(16'd2, 16'd1, 8'd9);
        queue_load(16'hFFFF, 16'hFFFF, 8'd1);
        // idle ticks while nothing has arrived, then the first runs
        for (i = 0; i < 3; i++)
            queue_tick();
        // loads after ticking: lowest priority soaker, priority and arrival ties
        queue_load(16'd0, 16'hFFFF, 8'd255);
        queue_load(16'd6, 16'd2, 8'd1);
        queue_load(16'd6, 16'd4, 8'd1);
        queue_load(16'd5, 16'd1, 8'd2);
        for (i = 0; i < 10; i++)
            queue_tick();
        n_counted = ticks_queued + loads_queued;

        // random part: mostly ticks, sparse loads landing near the current time
        pause_next = 1'b1;
        while (n_counted < ITEM_TARGET) begin
            if ($urandom_range(0, 39) == 0) begin
                a = ticks_queued + $urandom_range(0, 120);
                if ($urandom_range(0, 9) == 0)
                    a = $urandom_range(0, 65535);
                if (a > 65535)
                    a = 65535;
                b = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(1, 65535))
                                                : 16'($urandom_range(1, 40));
                p = $urandom_range(0, 1) ? 8'($urandom_range(1, 4))
                                         : 8'($urandom_range(1, 255));
                // loads past a full table are ignored and not counted
                if (loads_queued < MAX_PROCS)
                    n_counted++;
                queue_load(a[15:0], b, p);
            end
            else begin
                queue_tick();
                n_counted++;
            end
            if (n_counted == ITEM_TARGET / 2)
                pause_next = 1'b1;
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // wait for all requests and tick reports to drain
        do
            @(posedge clk);
        while (request_q.size() != 0 || req_valid || tick_reports_q.size() != 0);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/pps_pkg.sv
hdl/preemptive_priority_scheduler.sv
bench/tb.sv
